[sv/clse_pkg.sv]
// ----------------------------------------------------------------------------
// clse_pkg
// Shared constants, codes and types of the complex Laurent series evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package clse_pkg;

  localparam int MAX_POS_POWER = 16;
  localparam int MAX_NEG_POWER = 16;
  localparam int FRAC_BITS     = 20;
  localparam int VALUE_WIDTH   = 32;

  localparam int TABLE_DEPTH = MAX_NEG_POWER + MAX_POS_POWER + 1;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int SUM_W       = PROD_W + 2;
  localparam int NUM_W       = VALUE_WIDTH + 2 * FRAC_BITS;
  localparam int CNT_W       = $clog2(NUM_W + 1);

  // operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_POLE  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_LD0,
    S_MAC,
    S_NORM,
    S_DIV,
    S_DONE
  } state_t;

  // reciprocal unit status
  typedef struct packed {
    logic done;
    logic sat;
  } recip_stat_t;

endpackage

`default_nettype wire

[sv/clse_if.sv]
// ----------------------------------------------------------------------------
// clse_in_if / clse_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface clse_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [5:0]  power;
  logic signed [31:0] coeff_re;
  logic signed [31:0] coeff_im;
  logic signed [31:0] point_re;
  logic signed [31:0] point_im;

  modport source (output valid, operation, power, coeff_re, coeff_im, point_re, point_im,
                  input ready);
  modport sink   (input valid, operation, power, coeff_re, coeff_im, point_re, point_im,
                  output ready);
endinterface

interface clse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_re;
  logic signed [31:0] value_im;
  logic [1:0]         status;

  modport source (output valid, value_re, value_im, status, input ready);
  modport sink   (input valid, value_re, value_im, status, output ready);
endinterface

`default_nettype wire

[sv/complex_laurent_series_evaluator_top.sv]
// ----------------------------------------------------------------------------
// complex_laurent_series_evaluator_top
// Coefficient table for powers -16..+16 with add, evaluate and clear words.
//
// Command words enter on req, one result word per command leaves on rsp.
// One command is worked on at a time; req.ready is high while the block is
// free, also while a finished result still waits in the rsp register.
// An evaluate runs Horner in z over 16 steps on one shared 32x32
// multiplier; with negative-power terms present it then forms |z|^2 on
// that multiplier, runs the bit-serial reciprocal divider and does
// 16 more Horner steps in 1/z.
// The table sits in a one-port synchronous RAM, read then written back;
// per-entry valid bits make every entry read as zero after reset or clear.
// Reset (rst, synchronous) empties the table and drops any pending result.
// When rsp stalls, the result holds and the next command waits at the end
// of its work until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_laurent_series_evaluator_top (
  input  wire logic clk,
  input  wire logic rst,
  clse_in_if.sink   req,
  clse_out_if.source rsp
);

  localparam int VW    = clse_pkg::VALUE_WIDTH;
  localparam int FB    = clse_pkg::FRAC_BITS;
  localparam int DEPTH = clse_pkg::TABLE_DEPTH;
  localparam int IW    = clse_pkg::IDX_W;
  localparam int SW    = clse_pkg::SUM_W;
  localparam int RW    = SW + 2;
  localparam int NEG   = clse_pkg::MAX_NEG_POWER;
  localparam int POS   = clse_pkg::MAX_POS_POWER;

  typedef struct packed {
    logic                 sat;
    logic signed [VW-1:0] val;
  } sat_res_t;

  // clamp a wide signed value to the value range
  function automatic sat_res_t clamp(input logic signed [RW-1:0] v);
    sat_res_t r;
    r.sat = 1'b0;
    r.val = v[VW-1:0];
    if (v > RW'((RW'(1) <<< (VW - 1)) - RW'(1))) begin
      r.sat = 1'b1;
      r.val = {1'b0, {(VW - 1){1'b1}}};
    end else if (v < -(RW'(1) <<< (VW - 1))) begin
      r.sat = 1'b1;
      r.val = {1'b1, {(VW - 1){1'b0}}};
    end
    return r;
  endfunction

  // rounded, clamped sum / 2^FB + c
  function automatic sat_res_t round_acc(input logic signed [SW-1:0] s,
                                         input logic signed [VW-1:0] c);
    logic signed [RW-1:0] t;
    t = RW'(s) + (RW'(c) <<< FB) + (RW'(1) <<< (FB - 1));
    return clamp(t >>> FB);
  endfunction

  clse_pkg::state_t state, state_next;

  logic [1:0]              op_q;
  logic [1:0]              stat_q;
  logic [IW-1:0]           idx_q;
  logic [IW-1:0]           k_q;
  logic [2:0]              phase_q;
  logic                    neg_pass, has_neg, pole, sat_q;
  logic signed [VW-1:0]    cre, cim, zr, zi, xr, xi, accr, acci, pr, pi;
  logic signed [2*VW-1:0]  prod;
  logic signed [SW-1:0]    sumr, sumi;
  logic [DEPTH-1:0]        valid, nz;

  logic [2*VW-1:0]         tbl_mem [DEPTH];
  logic [2*VW-1:0]         rd_data;
  logic                    rd_vld;
  logic                    rd_en, mem_we;
  logic [IW-1:0]           rd_addr;
  logic signed [VW-1:0]    rd_re, rd_im, c_re, c_im;
  logic signed [VW-1:0]    mul_a, mul_b;
  logic                    accept, last_step, rstart;
  logic signed [IW:0]      pidx;
  logic                    in_range, z_zero, neg_any;
  sat_res_t                rnd_r, rnd_i, add_r, add_i, fin_r, fin_i;
  logic signed [VW-1:0]    wr, wi;
  clse_pkg::recip_stat_t   rs;

  assign accept    = req.valid && req.ready;
  assign pidx      = (IW + 1)'(req.power) + (IW + 1)'(NEG);
  assign in_range  = (req.power >= -6'(NEG)) && (req.power <= 6'(POS));
  assign z_zero    = (req.point_re == '0) && (req.point_im == '0);
  assign neg_any   = |nz[NEG-1:0];
  assign last_step = (k_q == IW'(NEG));

  // table read data; never-written entries read as zero
  assign rd_re = rd_vld ? rd_data[2*VW-1:VW] : '0;
  assign rd_im = rd_vld ? rd_data[VW-1:0] : '0;
  assign c_re  = (neg_pass && last_step) ? '0 : rd_re;
  assign c_im  = (neg_pass && last_step) ? '0 : rd_im;

  always_comb begin
    rnd_r = round_acc(sumr, c_re);
    rnd_i = round_acc(sumi, c_im);
    add_r = clamp(RW'(rd_re) + RW'(cre));
    add_i = clamp(RW'(rd_im) + RW'(cim));
    fin_r = clamp(RW'(pr) + RW'(accr));
    fin_i = clamp(RW'(pi) + RW'(acci));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      clse_pkg::S_IDLE: begin
        if (accept) begin
          case (req.operation)
            clse_pkg::OP_ADD: begin
              if (!in_range || (req.coeff_re == '0 && req.coeff_im == '0)) begin
                state_next = clse_pkg::S_DONE;
              end else begin
                state_next = clse_pkg::S_ADD;
              end
            end
            clse_pkg::OP_EVAL: begin
              state_next = (neg_any && z_zero) ? clse_pkg::S_DONE : clse_pkg::S_LD0;
            end
            default: state_next = clse_pkg::S_DONE;
          endcase
        end
      end
      clse_pkg::S_ADD: state_next = clse_pkg::S_DONE;
      clse_pkg::S_LD0: state_next = clse_pkg::S_MAC;
      clse_pkg::S_MAC: begin
        if (phase_q == 3'd5 && last_step) begin
          state_next = (!neg_pass && has_neg) ? clse_pkg::S_NORM : clse_pkg::S_DONE;
        end
      end
      clse_pkg::S_NORM: begin
        if (phase_q == 3'd3) state_next = clse_pkg::S_DIV;
      end
      clse_pkg::S_DIV: begin
        if (rs.done) state_next = clse_pkg::S_LD0;
      end
      clse_pkg::S_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = clse_pkg::S_IDLE;
      end
      default: state_next = clse_pkg::S_IDLE;
    endcase
  end

  // outputs: memory port, multiplier operands, divider start
  always_comb begin
    req.ready = (state == clse_pkg::S_IDLE);
    rd_en     = 1'b0;
    rd_addr   = '0;
    mem_we    = (state == clse_pkg::S_ADD);
    rstart    = (state == clse_pkg::S_NORM) && (phase_q == 3'd3);
    mul_a     = accr;
    mul_b     = xr;
    case (state)
      clse_pkg::S_IDLE: begin
        rd_en   = accept;
        rd_addr = (req.operation == clse_pkg::OP_ADD) ? pidx[IW-1:0] : IW'(DEPTH - 1);
      end
      clse_pkg::S_LD0: begin
        rd_en   = 1'b1;
        rd_addr = neg_pass ? IW'(1) : IW'(DEPTH - 2);
      end
      clse_pkg::S_MAC: begin
        rd_en   = (phase_q == 3'd5) && !last_step;
        rd_addr = neg_pass ? k_q + IW'(1) : k_q - IW'(1);
        case (phase_q)
          3'd1:    begin mul_a = acci; mul_b = xi; end
          3'd2:    begin mul_a = accr; mul_b = xi; end
          3'd3:    begin mul_a = acci; mul_b = xr; end
          default: begin mul_a = accr; mul_b = xr; end
        endcase
      end
      clse_pkg::S_NORM: begin
        mul_a = (phase_q == 3'd0) ? zr : zi;
        mul_b = (phase_q == 3'd0) ? zr : zi;
      end
      clse_pkg::S_DIV: begin
        rd_en   = rs.done;
        rd_addr = '0;
      end
      default: ;
    endcase
  end

  // coefficient table memory
  always_ff @(posedge clk) begin
    if (mem_we) tbl_mem[idx_q] <= {add_r.val, add_i.val};
    if (rd_en) begin
      rd_data <= tbl_mem[rd_addr];
      rd_vld  <= valid[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= clse_pkg::S_IDLE;
      valid     <= '0;
      nz        <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && req.operation == clse_pkg::OP_CLEAR) begin
        valid <= '0;
        nz    <= '0;
      end
      if (mem_we) begin
        valid[idx_q] <= 1'b1;
        nz[idx_q]    <= (add_r.val != '0) || (add_i.val != '0);
      end
      if (state == clse_pkg::S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      clse_pkg::S_IDLE: begin
        if (accept) begin
          op_q     <= req.operation;
          idx_q    <= pidx[IW-1:0];
          cre      <= req.coeff_re;
          cim      <= req.coeff_im;
          zr       <= req.point_re;
          zi       <= req.point_im;
          has_neg  <= neg_any;
          pole     <= neg_any && z_zero;
          neg_pass <= 1'b0;
          sat_q    <= 1'b0;
          stat_q   <= (req.operation == clse_pkg::OP_ADD && !in_range) ?
                      clse_pkg::ST_RANGE : clse_pkg::ST_OK;
        end
      end
      clse_pkg::S_ADD: begin
        if (add_r.sat || add_i.sat) stat_q <= clse_pkg::ST_SAT;
      end
      clse_pkg::S_LD0: begin
        accr    <= rd_re;
        acci    <= rd_im;
        xr      <= neg_pass ? wr : zr;
        xi      <= neg_pass ? wi : zi;
        k_q     <= neg_pass ? IW'(1) : IW'(DEPTH - 2);
        phase_q <= 3'd0;
      end
      clse_pkg::S_MAC: begin
        phase_q <= (phase_q == 3'd5) ? 3'd0 : phase_q + 3'd1;
        case (phase_q)
          3'd1: sumr <= SW'(prod);
          3'd2: sumr <= sumr - SW'(prod);
          3'd3: sumi <= SW'(prod);
          3'd4: sumi <= sumi + SW'(prod);
          3'd5: begin
            // no negative part: its accumulator stays zero for the final sum
            if (last_step && !neg_pass && !has_neg) begin
              accr <= '0;
              acci <= '0;
            end else begin
              accr <= rnd_r.val;
              acci <= rnd_i.val;
            end
            if (rnd_r.sat || rnd_i.sat) sat_q <= 1'b1;
            if (last_step) begin
              if (!neg_pass) begin
                pr <= rnd_r.val;
                pi <= rnd_i.val;
                if (has_neg) neg_pass <= 1'b1;
              end
            end else begin
              k_q <= neg_pass ? k_q + IW'(1) : k_q - IW'(1);
            end
          end
          default: ;
        endcase
      end
      clse_pkg::S_NORM: begin
        phase_q <= phase_q + 3'd1;
        if (phase_q == 3'd1) sumr <= SW'(prod);
        if (phase_q == 3'd2) sumr <= sumr + SW'(prod);
      end
      clse_pkg::S_DIV: begin
        if (rs.done && rs.sat) sat_q <= 1'b1;
      end
      clse_pkg::S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          if (op_q == clse_pkg::OP_EVAL && !pole) begin
            rsp.value_re <= fin_r.val;
            rsp.value_im <= fin_i.val;
            rsp.status   <= (sat_q || fin_r.sat || fin_i.sat) ?
                            clse_pkg::ST_SAT : clse_pkg::ST_OK;
          end else begin
            rsp.value_re <= '0;
            rsp.value_im <= '0;
            rsp.status   <= (op_q == clse_pkg::OP_EVAL) ? clse_pkg::ST_POLE :
                            (op_q == clse_pkg::OP_ADD) ? stat_q : clse_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
  end

  clse_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (rstart),
    .zr    (zr),
    .zi    (zi),
    .norm  (sumr[2*VW-1:0]),
    .wr    (wr),
    .wi    (wi),
    .stat  (rs)
  );

endmodule

`default_nettype wire

[sv/clse_recip.sv]
// ----------------------------------------------------------------------------
// clse_recip
// Two-lane restoring divider forming 1/z = conj(z)/|z|^2, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module clse_recip (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     start,
  input  wire logic signed [clse_pkg::VALUE_WIDTH-1:0]  zr,
  input  wire logic signed [clse_pkg::VALUE_WIDTH-1:0]  zi,
  input  wire logic [clse_pkg::PROD_W-1:0]              norm,
  output logic signed [clse_pkg::VALUE_WIDTH-1:0]       wr,
  output logic signed [clse_pkg::VALUE_WIDTH-1:0]       wi,
  output clse_pkg::recip_stat_t                         stat
);

  localparam int VW = clse_pkg::VALUE_WIDTH;
  localparam int NW = clse_pkg::NUM_W;
  localparam int PW = clse_pkg::PROD_W;

  logic                            busy;
  logic [clse_pkg::CNT_W-1:0]      cnt;
  logic [NW-1:0]                   num  [2];
  logic [PW-1:0]                   rem  [2];
  logic [NW-1:0]                   quo  [2];
  logic                            neg  [2];
  logic [VW-1:0]                   mag  [2];
  logic [PW:0]                     rsh  [2];
  logic [NW-1:0]                   lim  [2];
  logic [NW-1:0]                   qs   [2];
  logic [1:0]                      lsat;
  logic [VW-1:0]                   res  [2];
  logic                            fin;

  // lane signs and magnitudes: lane 0 divides zr, lane 1 divides -zi
  always_comb begin
    neg[0] = zr[VW-1];
    mag[0] = zr[VW-1] ? VW'(-zr) : VW'(zr);
    neg[1] = !zi[VW-1] && (zi != '0);
    mag[1] = zi[VW-1] ? VW'(-zi) : VW'(zi);
  end

  // per-lane trial subtract and final clamp
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rsh[l]  = {rem[l], num[l][NW-1]};
      lim[l]  = neg[l] ? (NW'(1) << (VW - 1)) : ((NW'(1) << (VW - 1)) - NW'(1));
      lsat[l] = quo[l] > lim[l];
      qs[l]   = lsat[l] ? lim[l] : quo[l];
      res[l]  = neg[l] ? VW'(~qs[l][VW-1:0] + VW'(1)) : qs[l][VW-1:0];
    end
  end

  // last cycle of a division
  assign fin = busy && !start && (cnt == '0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= fin;
      if (fin) stat.sat <= |lsat;
      if (start) begin
        busy <= 1'b1;
        cnt  <= clse_pkg::CNT_W'(NW);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - clse_pkg::CNT_W'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      for (int l = 0; l < 2; l++) begin
        num[l] <= {mag[l], {(2 * clse_pkg::FRAC_BITS){1'b0}}};
        rem[l] <= '0;
        quo[l] <= '0;
      end
    end else if (busy && cnt != '0) begin
      for (int l = 0; l < 2; l++) begin
        num[l] <= num[l] << 1;
        if (rsh[l] >= {1'b0, norm}) begin
          rem[l] <= PW'(rsh[l] - {1'b0, norm});
          quo[l] <= {quo[l][NW-2:0], 1'b1};
        end else begin
          rem[l] <= rsh[l][PW-1:0];
          quo[l] <= {quo[l][NW-2:0], 1'b0};
        end
      end
    end
    if (busy && cnt == '0) begin
      wr <= res[0];
      wi <= res[1];
    end
  end

endmodule

`default_nettype wire

[sv/clse_checker.sv]
// ----------------------------------------------------------------------------
// clse_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clse_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] value_re,
  input wire logic signed [31:0] value_im,
  input wire logic [1:0]         status
);

  // a pending result word is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one command at a time: busy right after a word is taken
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // range errors and poles carry a zero value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == clse_pkg::ST_RANGE || status == clse_pkg::ST_POLE)
    |-> value_re == '0 && value_im == '0)
    else $error("nonzero value with error status");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word after reset");

endmodule

bind complex_laurent_series_evaluator_top clse_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .value_re  (rsp.value_re),
  .value_im  (rsp.value_im),
  .status    (rsp.status)
);

`default_nettype wire

[dv/complex_laurent_series_evaluator_checker.sv]
// ----------------------------------------------------------------------------
// complex_laurent_series_evaluator_checker
// Watches the command and result channels of the Laurent series evaluator,
// keeps its own coefficient table, predicts each result word and compares
// it field by field against what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_laurent_series_evaluator_checker
  import clse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  clse_in_if        req,
  clse_out_if       rsp,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
    logic [1:0]         status;
  } result_t;

  localparam logic signed [127:0] VHI = 128'sd2147483647;
  localparam logic signed [127:0] VLO = -128'sd2147483648;

  longint  coeff_re_tbl [TABLE_DEPTH];
  longint  coeff_im_tbl [TABLE_DEPTH];
  result_t result_q [$];

  // clamp a wide signed value to the 32-bit value range
  function automatic longint clamp32(input logic signed [127:0] v, inout bit sat);
    if (v > VHI) begin
      sat = 1'b1;
      return longint'(VHI);
    end
    if (v < VLO) begin
      sat = 1'b1;
      return longint'(VLO);
    end
    return longint'(v);
  endfunction

  // one horner step: round(a*b + c), saturated per part
  function automatic void horner_step(input longint ar, ai, br, bi, cr, ci,
                                      output longint rr, ri, inout bit sat);
    logic signed [127:0] xr, xi, yr, yi, zr, zi, re, im, half;
    xr = ar; xi = ai; yr = br; yi = bi; zr = cr; zi = ci;
    half = 128'sd1 <<< (FRAC_BITS - 1);
    re = xr * yr - xi * yi + (zr <<< FRAC_BITS) + half;
    im = xr * yi + xi * yr + (zi <<< FRAC_BITS) + half;
    rr = clamp32(re >>> FRAC_BITS, sat);
    ri = clamp32(im >>> FRAC_BITS, sat);
  endfunction

  // v * 2^(2F) / n truncated toward zero, saturated
  function automatic longint recip_part(input longint v, input logic [127:0] n,
                                        inout bit sat);
    logic [127:0] num, quo, lim;
    num = (v < 0) ? 128'(-v) : 128'(v);
    num = num << (2 * FRAC_BITS);
    quo = num / n;
    lim = (v < 0) ? 128'd2147483648 : 128'd2147483647;
    if (quo > lim) begin
      sat = 1'b1;
      quo = lim;
    end
    return (v < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // series value at z, or pole
  function automatic result_t evaluate_series(input longint zr, zi);
    result_t r;
    bit      sat, has_neg;
    longint  pr, pi, nr, ni, wr, wi;
    logic signed [127:0] wzr, wzi;
    r = '{0, 0, ST_OK};
    sat = 1'b0;
    has_neg = 1'b0;
    nr = 0;
    ni = 0;
    for (int k = 0; k < MAX_NEG_POWER; k++)
      if (coeff_re_tbl[k] != 0 || coeff_im_tbl[k] != 0) has_neg = 1'b1;
    if (has_neg && zr == 0 && zi == 0) begin
      r.status = ST_POLE;
      return r;
    end
    pr = coeff_re_tbl[TABLE_DEPTH-1];
    pi = coeff_im_tbl[TABLE_DEPTH-1];
    for (int k = TABLE_DEPTH - 2; k >= MAX_NEG_POWER; k--)
      horner_step(pr, pi, zr, zi, coeff_re_tbl[k], coeff_im_tbl[k], pr, pi, sat);
    if (has_neg) begin
      wzr = zr;
      wzi = zi;
      wr = recip_part(zr, wzr * wzr + wzi * wzi, sat);
      wi = recip_part(-zi, wzr * wzr + wzi * wzi, sat);
      nr = coeff_re_tbl[0];
      ni = coeff_im_tbl[0];
      for (int k = 1; k < MAX_NEG_POWER; k++)
        horner_step(nr, ni, wr, wi, coeff_re_tbl[k], coeff_im_tbl[k], nr, ni, sat);
      horner_step(nr, ni, wr, wi, 0, 0, nr, ni, sat);
    end
    r.value_re = 32'(clamp32(128'(pr) + 128'(nr), sat));
    r.value_im = 32'(clamp32(128'(pi) + 128'(ni), sat));
    if (sat) r.status = ST_SAT;
    return r;
  endfunction

  // apply one command word to the table copy and work out its result
  function automatic result_t apply_word(input logic [1:0] op, input logic signed [5:0] pw,
                                         input longint cr, ci, zr, zi);
    result_t r;
    bit      sat;
    int      k;
    r = '{0, 0, ST_OK};
    sat = 1'b0;
    case (op)
      OP_ADD: begin
        if (pw < -MAX_NEG_POWER || pw > MAX_POS_POWER) begin
          r.status = ST_RANGE;
        end else if (cr != 0 || ci != 0) begin
          k = int'(pw) + MAX_NEG_POWER;
          coeff_re_tbl[k] = clamp32(128'(coeff_re_tbl[k]) + 128'(cr), sat);
          coeff_im_tbl[k] = clamp32(128'(coeff_im_tbl[k]) + 128'(ci), sat);
          if (sat) r.status = ST_SAT;
        end
      end
      OP_EVAL: r = evaluate_series(zr, zi);
      OP_CLEAR: begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          coeff_re_tbl[j] = 0;
          coeff_im_tbl[j] = 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fail_count++;
  endtask

  // predict on accepted commands, compare on accepted results
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        coeff_re_tbl[j] = 0;
        coeff_im_tbl[j] = 0;
      end
      result_q.delete();
      fail_count = 0;
    end else begin
      if (req.valid && req.ready)
        result_q.insert(result_q.size(),
                        apply_word(req.operation, req.power, longint'(req.coeff_re),
                                   longint'(req.coeff_im), longint'(req.point_re),
                                   longint'(req.point_im)));
      if (rsp.valid && rsp.ready) begin
        if (result_q.size() == 0) begin
          $display("result word with nothing expected");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (rsp.value_re !== want.value_re) report("value_re", rsp.value_re, want.value_re);
          if (rsp.value_im !== want.value_im) report("value_im", rsp.value_im, want.value_im);
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
        end
      end
    end
    pending = result_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

`default_nettype wire

[dv/complex_laurent_series_evaluator_top_tb.sv]
// ----------------------------------------------------------------------------
// complex_laurent_series_evaluator_top_tb
// Drives directed and random add, evaluate, clear and unused-code words into the block
// with random gaps on both channels, and gives the verdict from the
// checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_laurent_series_evaluator_top_tb;
  import clse_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst;
  int   fail_count, pending;
  int   idle_cycles;
  bit   no_gaps;
  int   n_add, n_eval, n_clear, n_unused;

  clse_in_if  req_if ();
  clse_out_if rsp_if ();

  complex_laurent_series_evaluator_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  complex_laurent_series_evaluator_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  // coefficient or point part: mostly near unity, sometimes any 32-bit value
  function automatic logic [31:0] draw_part(input int wide_pct);
    if ($urandom_range(0, 99) < wide_pct) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  // send one command word and wait for it to be taken
  task automatic send_word(input logic [1:0] op, input logic [5:0] pw,
                           input logic [31:0] cr, ci, zr, zi);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.power     <= pw;
    req_if.coeff_re  <= cr;
    req_if.coeff_im  <= ci;
    req_if.point_re  <= zr;
    req_if.point_im  <= zi;
    do @(posedge clk); while (!req_if.ready);
    case (op)
      OP_ADD:   n_add++;
      OP_EVAL:  n_eval++;
      OP_CLEAR: n_clear++;
      default:  n_unused++;
    endcase
  endtask

  task automatic add_term(input int pw, input logic [31:0] cr, ci);
    send_word(OP_ADD, 6'(pw), cr, ci, $urandom, $urandom);
  endtask

  task automatic eval_at(input logic [31:0] zr, zi);
    send_word(OP_EVAL, 6'($urandom), $urandom, $urandom, zr, zi);
  endtask

  // result side back-pressure
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int sel;
    idle_cycles = 0;
    no_gaps = 1'b0;
    n_add = 0; n_eval = 0; n_clear = 0; n_unused = 0;
    rst <= 1'b1;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_ADD;
    req_if.power     <= '0;
    req_if.coeff_re  <= '0;
    req_if.coeff_im  <= '0;
    req_if.point_re  <= '0;
    req_if.point_im  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, window edges, rejects, zero coeff, saturation, pole
    eval_at(32'h0, 32'h0);
    add_term(16, 32'h0010_0000, 32'hFFF0_0000);
    add_term(0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_term(0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_term(17, 32'h0010_0000, 32'h0010_0000);
    add_term(-17, 32'h0010_0000, 32'h0010_0000);
    add_term(-32, 32'h0010_0000, 32'h0010_0000);
    add_term(31, 32'h0010_0000, 32'h0010_0000);
    add_term(5, 32'h0, 32'h0);
    eval_at(32'h0010_0000, 32'h0);
    eval_at(32'h0, 32'h0);
    eval_at(32'h7FFF_FFFF, 32'h8000_0000);
    add_term(-16, 32'h0008_0000, 32'h0000_0001);
    add_term(-1, 32'hFFF8_0000, 32'h0004_0000);
    eval_at(32'h0, 32'h0);
    eval_at(32'h0000_0001, 32'h0);
    eval_at(32'h8000_0000, 32'h7FFF_FFFF);
    eval_at(32'h0010_0000, 32'h0010_0000);
    send_word(OP_UNUSED, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, '0, '0, '0, '0, '0);
    eval_at(32'h0, 32'h0);
    add_term(-8, 32'h8000_0000, 32'h7FFF_FFFF);
    eval_at(32'h0000_8000, 32'hFFFF_8000);

    // random: mostly in-window adds and evaluates near the unit circle
    for (int i = 0; i < 1750; i++) begin
      no_gaps = (i % 400) >= 340;
      if (i == 900) begin
        req_if.valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 55)
        add_term($urandom_range(0, 32) - 16, draw_part(8), draw_part(8));
      else if (sel < 88)
        eval_at(($urandom_range(0, 19) == 0) ? 32'h0 : draw_part(10),
                ($urandom_range(0, 19) == 0) ? 32'h0 : draw_part(10));
      else if (sel < 94)
        send_word(OP_CLEAR, 6'($urandom), $urandom, $urandom, $urandom, $urandom);
      else
        send_word(2'($urandom), 6'($urandom), $urandom, $urandom, $urandom, $urandom);
    end
    req_if.valid <= 1'b0;

    @(negedge clk);
    wait (pending == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d adds, %0d evaluates, %0d clears and %0d unused-code words",
             n_add, n_eval, n_clear, n_unused);
    $display("with random gaps and stalls on both channels, %0d mismatches", fail_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/clse_pkg.sv
sv/clse_if.sv
sv/clse_recip.sv
sv/complex_laurent_series_evaluator_top.sv
sv/clse_checker.sv
dv/complex_laurent_series_evaluator_checker.sv
dv/complex_laurent_series_evaluator_top_tb.sv
